// File: hdl/cmd_pkg.sv
`timescale 1ns / 1ps

package cmd_pkg;

    // field widths
    localparam int YEAR_W    = 14;
    localparam int MON_W     = 4;
    localparam int DAY_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MIN_W     = 6;
    localparam int ELAPSED_W = 18;
    // signed working width for minute counts, covers both signs of any span
    localparam int CALC_W    = 20;

    // minute constants
    localparam logic signed [CALC_W-1:0] MIN_PER_DAY  = CALC_W'(1440);
    localparam logic signed [CALC_W-1:0] MIN_PER_HOUR = CALC_W'(60);
    localparam logic signed [CALC_W-1:0] MIN_31_DAYS  = CALC_W'(44640);

    // month codes
    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_NOV = MON_W'(11);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

    // reciprocal of 25: 5243 / 2^17, exact floor for 14-bit years
    localparam int          RECIP25_W     = 13;
    localparam int          RECIP25_SHIFT = 17;
    localparam logic [RECIP25_W-1:0] RECIP25 = RECIP25_W'(5243);

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
    } t_stamp;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_minutes;
        logic                 error;
    } t_result;

    // days in a month, zero for a code that is no month
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MON_FEB:                            len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:            len = DAY_W'(30);
            default:                            len = '0;
        endcase
        return len;
    endfunction

    // gregorian leap rule: 100 | y <=> 4 | y and 25 | y; 400 | y <=> 16 | y and 25 | y
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W+RECIP25_W-1:0] prod;
        logic [YEAR_W-1:0]           quot;
        logic [YEAR_W-1:0]           back;
        logic                        div4;
        logic                        div16;
        logic                        div25;
        prod  = (YEAR_W+RECIP25_W)'(y) * (YEAR_W+RECIP25_W)'(RECIP25);
        quot  = YEAR_W'(prod >> RECIP25_SHIFT);
        back  = (quot << 4) + (quot << 3) + quot;
        div4  = (y[1:0] == 2'b00);
        div16 = (y[3:0] == 4'b0000);
        div25 = (back == y);
        return (div4 && !div25) || (div16 && div25);
    endfunction

endpackage

// File: hdl/cmd_calc.sv
`timescale 1ns / 1ps

module cmd_calc (
    input  cmd_pkg::t_stamp  i_s,
    input  cmd_pkg::t_stamp  i_e,
    output cmd_pkg::t_result o_res
);
    import cmd_pkg::*;

    logic                      leap;
    logic                      later;
    logic                      mon_ok;
    logic                      case_ok;
    logic                      ok;
    logic [MON_W-1:0]          gap;
    logic [YEAR_W:0]           year_next;
    logic signed [CALC_W-1:0]  len_s;
    logic signed [CALC_W-1:0]  len_n;
    logic signed [CALC_W-1:0]  s_d, s_h, s_m;
    logic signed [CALC_W-1:0]  e_d, e_h, e_m;
    logic signed [CALC_W-1:0]  to_end;
    logic signed [CALC_W-1:0]  from_s;
    logic signed [CALC_W-1:0]  from_e;
    logic signed [CALC_W-1:0]  total;

    // leap year and month lengths of the start month and the one after
    assign leap  = is_leap(i_s.year);
    assign len_s = $signed(CALC_W'(month_len(i_s.month, leap)));
    assign len_n = $signed(CALC_W'(month_len(i_s.month + MON_W'(1), leap)));

    // raw fields widened to the working width
    assign s_d = $signed(CALC_W'(i_s.day));
    assign s_h = $signed(CALC_W'(i_s.hour));
    assign s_m = $signed(CALC_W'(i_s.minute));
    assign e_d = $signed(CALC_W'(i_e.day));
    assign e_h = $signed(CALC_W'(i_e.hour));
    assign e_m = $signed(CALC_W'(i_e.minute));

    // minutes to the end of the start month and from the start of each month
    assign to_end = MIN_PER_DAY - (s_h * MIN_PER_HOUR + s_m) + (len_s - s_d) * MIN_PER_DAY;
    assign from_s = (s_d - CALC_W'(1)) * MIN_PER_DAY + s_h * MIN_PER_HOUR + s_m;
    assign from_e = (e_d - CALC_W'(1)) * MIN_PER_DAY + e_h * MIN_PER_HOUR + e_m;

    // order test over the whole timestamp as one unsigned word
    assign later  = (i_s > i_e);
    assign mon_ok = (i_s.month >= MON_JAN) && (i_s.month <= MON_DEC)
                 && (i_e.month >= MON_JAN) && (i_e.month <= MON_DEC);
    assign gap       = i_e.month - i_s.month;
    assign year_next = (YEAR_W+1)'(i_s.year) + (YEAR_W+1)'(1);

    // span cases
    always_comb begin
        case_ok = 1'b0;
        total   = '0;
        if (i_s.year != i_e.year) begin
            if (year_next == (YEAR_W+1)'(i_e.year)
                    && (i_s.month == MON_NOV || i_s.month == MON_DEC)
                    && (i_e.month == MON_JAN || i_e.month == MON_FEB)) begin
                total = ((i_s.month == MON_NOV) ? MIN_31_DAYS : '0) + to_end
                      + ((i_e.month == MON_FEB) ? MIN_31_DAYS : '0) + from_e;
                case_ok = 1'b1;
            end
        end else if (i_s.month != i_e.month) begin
            if (gap <= MON_W'(2)) begin
                total = to_end + from_e
                      + ((gap == MON_W'(2)) ? len_n * MIN_PER_DAY : '0);
                case_ok = 1'b1;
            end
        end else begin
            total   = from_e - from_s;
            case_ok = 1'b1;
        end
    end

    // result word, count forced to zero on error
    assign ok = !later && mon_ok && case_ok && !total[CALC_W-1];
    assign o_res.elapsed_minutes = ok ? total[ELAPSED_W-1:0] : '0;
    assign o_res.error           = !ok;

endmodule

// File: hdl/calendar_minute_difference_core.sv
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// command  | start, busy            | i_start_* and i_end_* (year .. minute)
// result   | o_done (one cycle)     | o_elapsed_minutes, o_error
//
// one word is taken every cycle; busy is never raised
// the word passes the input register, then month table, leap test and constant
// multiplies into the result register, and o_done rises as the result is written
// synchronous active-low reset clears both valid flags
// the receiver cannot stall, so no result is ever held back

module calendar_minute_difference_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cmd_pkg::YEAR_W-1:0]      i_start_year,
    input  logic [cmd_pkg::MON_W-1:0]       i_start_month,
    input  logic [cmd_pkg::DAY_W-1:0]       i_start_day,
    input  logic [cmd_pkg::HOUR_W-1:0]      i_start_hour,
    input  logic [cmd_pkg::MIN_W-1:0]       i_start_minute,
    input  logic [cmd_pkg::YEAR_W-1:0]      i_end_year,
    input  logic [cmd_pkg::MON_W-1:0]       i_end_month,
    input  logic [cmd_pkg::DAY_W-1:0]       i_end_day,
    input  logic [cmd_pkg::HOUR_W-1:0]      i_end_hour,
    input  logic [cmd_pkg::MIN_W-1:0]       i_end_minute,
    output logic                            o_done,
    output logic [cmd_pkg::ELAPSED_W-1:0]   o_elapsed_minutes,
    output logic                            o_error
);
    import cmd_pkg::*;

    logic    r_in_vld;
    t_stamp  r_s;
    t_stamp  r_e;
    logic    r_out_vld;
    t_result r_res;
    t_result n_res;
    logic    accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
        if (accept) begin
            r_s <= '{i_start_year, i_start_month, i_start_day, i_start_hour, i_start_minute};
            r_e <= '{i_end_year, i_end_month, i_end_day, i_end_hour, i_end_minute};
        end
    end

    // minute arithmetic
    cmd_calc u_calc (
        .i_s   (r_s),
        .i_e   (r_e),
        .o_res (n_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        if (r_in_vld) begin
            r_res <= n_res;
        end
    end

    assign o_done            = r_out_vld;
    assign o_elapsed_minutes = r_res.elapsed_minutes;
    assign o_error           = r_res.error;

endmodule

// File: dv/tb_calendar_minute_difference_core.sv
`timescale 1ns / 1ps

module tb_calendar_minute_difference_core;
    import cmd_pkg::*;

    localparam int MINS_PER_HOUR      = 60;
    localparam int MINS_PER_DAY       = 1440;
    localparam int MINS_IN_LONG_MONTH = 44640;
    localparam int RANDOM_WORDS       = 1675;
    localparam int QUIET_LIMIT        = 500;
    localparam int DRAIN_CYCLES       = 8;
    localparam int MAX_IDLE           = 19;
    localparam int STAMP_PAIR_W       = 2 * $bits(t_stamp);
    // days per month code, zero where the code is no month
    localparam int DAYS_IN_MONTH [16] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31,
                                          0, 0, 0};

    typedef struct {
        t_stamp from_ts;
        t_stamp to_ts;
        bit     known;
        int     want_min;
        bit     want_err;
    } t_span_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 o_done;
    logic [ELAPSED_W-1:0] o_elapsed_minutes;
    logic                 o_error;

    t_stamp    drv_from;
    t_stamp    drv_to;
    bit        drv_known;
    t_result   drv_answer;
    t_result   pending_spans [$];
    t_span_row span_table [$];
    int        fail_count;
    int        quiet_cycles;

    calendar_minute_difference_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_start_year      (drv_from.year),
        .i_start_month     (drv_from.month),
        .i_start_day       (drv_from.day),
        .i_start_hour      (drv_from.hour),
        .i_start_minute    (drv_from.minute),
        .i_end_year        (drv_to.year),
        .i_end_month       (drv_to.month),
        .i_end_day         (drv_to.day),
        .i_end_hour        (drv_to.hour),
        .i_end_minute      (drv_to.minute),
        .o_done            (o_done),
        .o_elapsed_minutes (o_elapsed_minutes),
        .o_error           (o_error)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic bit leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int month_days(input int m, input bit leap);
        if (m == MON_FEB && leap)
            return 29;
        return DAYS_IN_MONTH[m & 15];
    endfunction

    function automatic int minutes_into_month(input t_stamp t);
        return (int'(t.day) - 1) * MINS_PER_DAY + int'(t.hour) * MINS_PER_HOUR + int'(t.minute);
    endfunction

    function automatic int minutes_to_month_end(input t_stamp t, input bit leap);
        return MINS_PER_DAY - (int'(t.hour) * MINS_PER_HOUR + int'(t.minute))
             + (month_days(int'(t.month), leap) - int'(t.day)) * MINS_PER_DAY;
    endfunction

    // expected elapsed minutes and error flag for one word
    function automatic t_result minutes_between(input t_stamp s, input t_stamp e);
        t_result r;
        int      total;
        int      gap;
        bit      ok;
        bit      leap;
        total = 0;
        ok    = 1'b0;
        leap  = leap_year(int'(s.year));
        // packed fields run year down to minute, so > is the lexicographic order
        if (!(s > e) && s.month >= MON_JAN && s.month <= MON_DEC
                && e.month >= MON_JAN && e.month <= MON_DEC) begin
            if (s.year != e.year) begin
                // only nov or dec into jan or feb of the next year
                if (int'(e.year) == int'(s.year) + 1 && (s.month == MON_NOV || s.month == MON_DEC)
                        && (e.month == MON_JAN || e.month == MON_FEB)) begin
                    total = (s.month == MON_NOV ? MINS_IN_LONG_MONTH : 0)
                          + minutes_to_month_end(s, leap)
                          + (e.month == MON_FEB ? MINS_IN_LONG_MONTH : 0)
                          + minutes_into_month(e);
                    ok = 1'b1;
                end
            end else if (s.month != e.month) begin
                gap = int'(e.month) - int'(s.month);
                if (gap > 0 && gap <= 2) begin
                    total = minutes_to_month_end(s, leap) + minutes_into_month(e);
                    if (gap == 2)
                        total += month_days(int'(s.month) + 1, leap) * MINS_PER_DAY;
                    ok = 1'b1;
                end
            end else begin
                total = minutes_into_month(e) - minutes_into_month(s);
                ok = 1'b1;
            end
            if (total < 0)
                ok = 1'b0;
        end
        r.elapsed_minutes = ok ? ELAPSED_W'(total) : '0;
        r.error           = !ok;
        return r;
    endfunction

    function automatic t_stamp make_stamp(input int y, input int mo, input int d, input int h,
                                          input int mi);
        t_stamp t;
        t.year   = YEAR_W'(y);
        t.month  = MON_W'(mo);
        t.day    = DAY_W'(d);
        t.hour   = HOUR_W'(h);
        t.minute = MIN_W'(mi);
        return t;
    endfunction

    // mostly in-range day, hour and minute, now and then the raw field range
    function automatic t_stamp rand_stamp(input int y, input int mo);
        if ($urandom_range(0, 15) == 0)
            return make_stamp(y, mo, $urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 63));
        return make_stamp(y, mo, $urandom_range(1, month_days(mo, leap_year(y))),
                          $urandom_range(0, 23), $urandom_range(0, 59));
    endfunction

    // centuries now and then so the leap rule exceptions come up
    function automatic int pick_year(input int top);
        if ($urandom_range(0, 7) == 0)
            return 100 * $urandom_range(0, top / 100);
        return $urandom_range(0, top);
    endfunction

    // drive one word at the falling edge and hold it until taken
    task automatic send_span(input t_stamp from_ts, input t_stamp to_ts, input bit known,
                             input t_result answer, input int idle);
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        start      <= 1'b1;
        drv_from   <= from_ts;
        drv_to     <= to_ts;
        drv_known  <= known;
        drv_answer <= answer;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    // result check, expectation capture and watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_spans.size() == 0) begin
                    $error("result word with none pending: elapsed_minutes %0d error %0b",
                           o_elapsed_minutes, o_error);
                    fail_count++;
                end else begin
                    want = pending_spans.pop_front();
                    if (o_elapsed_minutes !== want.elapsed_minutes) begin
                        $error("elapsed_minutes: expected %0d, actual %0d",
                               want.elapsed_minutes, o_elapsed_minutes);
                        fail_count++;
                    end
                    if (o_error !== want.error) begin
                        $error("error: expected %0b, actual %0b", want.error, o_error);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                pending_spans.push_back(drv_known ? drv_answer : minutes_between(drv_from, drv_to));
            if (o_done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_calendar_minute_difference_core failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_stamp a;
        t_stamp b;
        int     kind;
        int     sy;
        int     sm;
        int     em;
        int     g;
        int     idle;
        start        = 1'b0;
        drv_from     = '0;
        drv_to       = '0;
        drv_known    = 1'b0;
        drv_answer   = '0;
        i_rst_n      = 1'b0;
        fail_count   = 0;
        quiet_cycles = 0;

        // directed spans: from, to, answer known, minutes, error
        // equal stamps, start after end, no-month codes at both extremes
        span_table.push_back('{make_stamp(2024, 1, 15, 12, 30), make_stamp(2024, 1, 15, 12, 30),
                               1, 0, 0});
        span_table.push_back('{make_stamp(2025, 3, 1, 0, 0), make_stamp(2024, 3, 1, 0, 0), 1, 0, 1});
        span_table.push_back('{make_stamp(0, 0, 0, 0, 0), make_stamp(0, 0, 0, 0, 0), 1, 0, 1});
        span_table.push_back('{make_stamp(16383, 15, 31, 31, 63), make_stamp(16383, 15, 31, 31, 63),
                               1, 0, 1});
        span_table.push_back('{make_stamp(16383, 1, 1, 0, 0), make_stamp(0, 1, 1, 0, 0), 1, 0, 1});
        span_table.push_back('{make_stamp(2023, 12, 1, 0, 0), make_stamp(2023, 13, 1, 0, 0),
                               1, 0, 1});
        // whole month, month and year boundaries by one minute
        span_table.push_back('{make_stamp(2023, 1, 1, 0, 0), make_stamp(2023, 1, 31, 23, 59),
                               1, 44639, 0});
        span_table.push_back('{make_stamp(2023, 1, 31, 23, 59), make_stamp(2023, 2, 1, 0, 0),
                               1, 1, 0});
        span_table.push_back('{make_stamp(2023, 12, 31, 23, 59), make_stamp(2024, 1, 1, 0, 0),
                               1, 1, 0});
        // unsupported spans
        span_table.push_back('{make_stamp(2023, 1, 10, 0, 0), make_stamp(2023, 4, 10, 0, 0), 1, 0, 1});
        span_table.push_back('{make_stamp(2023, 10, 31, 0, 0), make_stamp(2024, 1, 1, 0, 0), 1, 0, 1});
        span_table.push_back('{make_stamp(2023, 12, 1, 0, 0), make_stamp(2025, 1, 1, 0, 0), 1, 0, 1});
        span_table.push_back('{make_stamp(2023, 11, 30, 23, 59), make_stamp(2024, 3, 1, 0, 0),
                               1, 0, 1});
        // raw out-of-range fields that drive the count negative, and a start one minute after the end
        span_table.push_back('{make_stamp(2023, 5, 10, 0, 63), make_stamp(2023, 5, 10, 1, 0), 1, 0, 1});
        span_table.push_back('{make_stamp(2023, 4, 31, 23, 0), make_stamp(2023, 5, 1, 0, 0), 1, 0, 1});
        span_table.push_back('{make_stamp(2023, 5, 10, 10, 31), make_stamp(2023, 5, 10, 10, 30),
                               1, 0, 1});
        // one- and two-month spans, mostly over february, across the leap rule cases
        span_table.push_back('{make_stamp(2024, 1, 15, 6, 7), make_stamp(2024, 3, 1, 8, 9), 0, 0, 0});
        span_table.push_back('{make_stamp(2023, 1, 15, 6, 7), make_stamp(2023, 3, 1, 8, 9), 0, 0, 0});
        span_table.push_back('{make_stamp(2000, 1, 31, 0, 0), make_stamp(2000, 3, 31, 0, 0), 0, 0, 0});
        span_table.push_back('{make_stamp(1900, 1, 31, 0, 0), make_stamp(1900, 3, 31, 0, 0), 0, 0, 0});
        span_table.push_back('{make_stamp(0, 2, 1, 0, 0), make_stamp(0, 3, 1, 0, 0), 0, 0, 0});
        span_table.push_back('{make_stamp(2023, 3, 5, 1, 1), make_stamp(2023, 5, 20, 2, 2), 0, 0, 0});
        // longest year change, a change from 9999 to 10000, and one at the top of the range
        span_table.push_back('{make_stamp(2023, 11, 1, 0, 0), make_stamp(2024, 2, 31, 23, 59),
                               0, 0, 0});
        span_table.push_back('{make_stamp(9999, 12, 2, 3, 4), make_stamp(10000, 2, 29, 5, 6), 0, 0, 0});
        span_table.push_back('{make_stamp(16382, 11, 30, 0, 0), make_stamp(16383, 1, 31, 31, 63),
                               0, 0, 0});

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (span_table[n])
            send_span(span_table[n].from_ts, span_table[n].to_ts, span_table[n].known,
                      '{elapsed_minutes: ELAPSED_W'(span_table[n].want_min),
                        error: span_table[n].want_err},
                      $urandom_range(0, MAX_IDLE));

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(0, 99);
            sy   = pick_year(16382);
            if (kind < 25) begin
                // same month
                sm = $urandom_range(1, 12);
                a  = rand_stamp(sy, sm);
                b  = rand_stamp(sy, sm);
            end else if (kind < 50) begin
                // one or two months later in the same year
                g = $urandom_range(1, 2);
                sm = $urandom_range(1, 12 - g);
                a  = rand_stamp(sy, sm);
                b  = rand_stamp(sy, sm + g);
            end else if (kind < 70) begin
                // nov or dec into jan or feb
                sm = $urandom_range(MON_NOV, MON_DEC);
                em = $urandom_range(MON_JAN, MON_FEB);
                a  = rand_stamp(sy, sm);
                b  = rand_stamp(sy + 1, em);
            end else if (kind < 80) begin
                // any months of one year, unsupported gaps included
                a = rand_stamp(sy, $urandom_range(1, 12));
                b = rand_stamp(sy, $urandom_range(1, 12));
            end else if (kind < 88) begin
                // years a little apart, any months
                a = rand_stamp(sy, $urandom_range(1, 12));
                b = rand_stamp(sy + $urandom_range(0, 1), $urandom_range(1, 12));
            end else begin
                // raw bits in every field
                {a, b} = STAMP_PAIR_W'({$urandom(), $urandom(), $urandom()});
            end
            // mostly put well-formed pairs in order, leave some reversed
            if (kind < 88 && $urandom_range(0, 9) != 0 && a > b)
                {a, b} = {b, a};
            // hold off until the pipeline is empty now and then
            if (n % 400 == 199) begin
                start <= 1'b0;
                @(negedge i_clk);
                while (pending_spans.size() != 0) @(negedge i_clk);
            end
            // stretches of back-to-back words between idle stretches
            idle = ((n / 150) % 4 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
            send_span(a, b, 1'b0, '0, idle);
        end
        start <= 1'b0;

        // drain
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_calendar_minute_difference_core passed");
        else
            $display("tb_calendar_minute_difference_core failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/cmd_pkg.sv
hdl/cmd_calc.sv
hdl/calendar_minute_difference_core.sv
dv/tb_calendar_minute_difference_core.sv
